>>> hw/rtl/mandel_pkg.sv
// Shared types, constants and helpers for the escape-time pixel evaluator.
package mandel_pkg;

  localparam int Q_W        = 32;  // Q4.28 word
  localparam int FRAC_W     = 28;
  localparam int VIEW_W     = 31;  // view registers as stored
  localparam int PIX_W      = 10;
  localparam int OFS_W      = 12;
  localparam int COLOR_W    = 24;
  localparam int ITER_W     = 9;
  localparam int CNT_W      = 13;  // iteration counter, holds an iteration limit up to 8191
  localparam int PROD_W     = 42;  // signed pixel index times view span
  localparam int DIV_W      = 41;  // magnitude of that product
  localparam int WIDE_W     = 43;  // mapping and update sums before saturation
  localparam int NUM_CELLS  = 2;   // iteration cells in the ring
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int COLOR_STEP = 30;

  localparam logic [COLOR_W-1:0] INSIDE_COLOR = 24'h000000;
  // |z|^2 bound of 4.0 with 56 fraction bits
  localparam logic [2*Q_W-1:0]   ESC_LIMIT    = 64'h0400_0000_0000_0000;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_RE_START  = 3'd0,
    REG_RE_END    = 3'd1,
    REG_IM_START  = 3'd2,
    REG_IM_END    = 3'd3,
    REG_COLOR_OFS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } mandel_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [ITER_W-1:0]  iter_count;
    logic               inside_set;
  } mandel_out_t;

  // One pixel's iteration state as it moves from cell to cell
  typedef struct packed {
    logic                    vld;
    logic                    done;
    logic signed [Q_W-1:0]   zr;
    logic signed [Q_W-1:0]   zi;
    logic signed [Q_W-1:0]   cr;
    logic signed [Q_W-1:0]   ci;
    logic        [CNT_W-1:0] cnt;
  } mandel_tok_t;

  // Clamp a wide signed sum to the Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-Q_W:0] hi;
    logic signed [Q_W-1:0] res;
    hi = v[WIDE_W-1:Q_W-1];
    if ((&hi) || !(|hi)) begin
      res = v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/mandelbrot_escape_time_pixel.sv
// Top level: view mapping, iteration cell ring, colour stage and register port.
//
// Usage: present a pixel (column, row) on the in_ channel; the block maps it to
// c in the programmed view, iterates z = z*z + c in a ring of iteration cells
// and returns one result (colour, iteration count, inside flag) on the out_
// channel. One pixel is evaluated at a time; in_stall is high from the
// transfer of a pixel until its result has moved into the output register.
// From the input transfer to out_valid the block forms the view span, the product,
// the reciprocal divide, the clamp and the ring load, then visits the ring cells in
// turn. n iterations take n+1 visits rounded up to a full pass of the two-cell ring.
// The next pixel can be taken once the result lands in the output register.
// The result register lets the next pixel be taken while a result waits.
// While out_stall blocks a full output register a finished pixel keeps circling
// the ring and leaves once the register frees up; nothing is dropped.
// View registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// Reset: synchronous, active low; view returns to -2.0..1.0 by -1.5..1.5,
// colour offset 0, ring and output empty.
module mandelbrot_escape_time_pixel import mandel_pkg::*; #(
  parameter int MAX_ITER   = 256,
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mandel_in_t            in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mandel_out_t           out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITER);

  localparam logic signed [VIEW_W-1:0] RST_RE_START = VIEW_W'(-536870912);
  localparam logic signed [VIEW_W-1:0] RST_RE_END   = VIEW_W'(268435456);
  localparam logic signed [VIEW_W-1:0] RST_IM_START = VIEW_W'(-402653184);
  localparam logic signed [VIEW_W-1:0] RST_IM_END   = VIEW_W'(402653184);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_PROD, S_START, S_DIV, S_MAP, S_LOAD, S_RUN
  } state_t;

  state_t state_r, state_nxt;

  logic signed [VIEW_W-1:0] re_start_r, re_end_r, im_start_r, im_end_r;
  logic        [OFS_W-1:0]  color_ofs_r;

  logic [PIX_W-1:0]         col_r, row_r;
  logic signed [Q_W-1:0]    diff_re_r, diff_im_r;
  logic signed [PROD_W-1:0] prod_re_r, prod_im_r;
  logic signed [Q_W-1:0]    cr_r, ci_r;

  logic                     out_valid_r;
  mandel_out_t              out_data_r;

  logic                     in_xfer;
  logic                     cfg_wr;
  logic [2:0]               reg_idx;

  logic                     div_start;
  logic [DIV_W-1:0]         mag_re, mag_im;
  logic                     div_re_done, div_im_done;
  logic [DIV_W-1:0]         div_re_q, div_im_q;
  logic signed [WIDE_W-1:0] q_re_w, q_im_w, qs_re, qs_im;
  logic signed [Q_W-1:0]    cr_nxt, ci_nxt;

  mandel_tok_t              cell_in  [NUM_CELLS];
  mandel_tok_t              cell_out [NUM_CELLS];
  mandel_tok_t              last_tok;
  mandel_tok_t              head_tok;
  logic                     exit_ok;
  mandel_out_t              result;
  logic [COLOR_W-1:0]       cnt_wide;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_start_r  <= RST_RE_START;
      re_end_r    <= RST_RE_END;
      im_start_r  <= RST_IM_START;
      im_end_r    <= RST_IM_END;
      color_ofs_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RE_START:  re_start_r  <= pwdata[VIEW_W-1:0];
        REG_RE_END:    re_end_r    <= pwdata[VIEW_W-1:0];
        REG_IM_START:  im_start_r  <= pwdata[VIEW_W-1:0];
        REG_IM_END:    im_end_r    <= pwdata[VIEW_W-1:0];
        REG_COLOR_OFS: color_ofs_r <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RE_START:  prdata = CFG_DATA_W'(re_start_r);
      REG_RE_END:    prdata = CFG_DATA_W'(re_end_r);
      REG_IM_START:  prdata = CFG_DATA_W'(im_start_r);
      REG_IM_END:    prdata = CFG_DATA_W'(im_end_r);
      REG_COLOR_OFS: prdata = CFG_DATA_W'(color_ofs_r);
      default:       prdata = '0;
    endcase
  end

  // View mapping datapath
  assign div_start = (state_r == S_START);
  assign mag_re = DIV_W'(prod_re_r[PROD_W-1] ? -prod_re_r : prod_re_r);
  assign mag_im = DIV_W'(prod_im_r[PROD_W-1] ? -prod_im_r : prod_im_r);

  mandel_div #(.DIVISOR(IMG_WIDTH)) u_div_re (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_re),
    .done     (div_re_done),
    .quotient (div_re_q)
  );

  mandel_div #(.DIVISOR(IMG_HEIGHT)) u_div_im (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_im),
    .done     (div_im_done),
    .quotient (div_im_q)
  );

  // Quotients truncate toward zero: restore the sign after the magnitude divide
  always_comb begin
    q_re_w = {2'b00, div_re_q};
    q_im_w = {2'b00, div_im_q};
    qs_re  = prod_re_r[PROD_W-1] ? -q_re_w : q_re_w;
    qs_im  = prod_im_r[PROD_W-1] ? -q_im_w : q_im_w;
    cr_nxt = sat_q(WIDE_W'(re_start_r) + qs_re);
    ci_nxt = sat_q(WIDE_W'(im_end_r) - qs_im);
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col_r <= in_data.pixel_col;
      row_r <= in_data.pixel_row;
    end
    if (state_r == S_DIFF) begin
      diff_re_r <= Q_W'(re_end_r) - Q_W'(re_start_r);
      diff_im_r <= Q_W'(im_end_r) - Q_W'(im_start_r);
    end
    if (state_r == S_PROD) begin
      prod_re_r <= $signed({1'b0, col_r}) * diff_re_r;
      prod_im_r <= $signed({1'b0, row_r}) * diff_im_r;
    end
    if (state_r == S_MAP) begin
      cr_r <= cr_nxt;
      ci_r <= ci_nxt;
    end
  end

  // Iteration ring
  assign last_tok = cell_out[NUM_CELLS-1];
  assign exit_ok  = last_tok.vld && last_tok.done && (!out_valid_r || !out_stall);

  always_comb begin
    if (state_r == S_LOAD) begin
      head_tok.vld  = 1'b1;
      head_tok.done = 1'b0;
      head_tok.zr   = '0;
      head_tok.zi   = '0;
      head_tok.cr   = cr_r;
      head_tok.ci   = ci_r;
      head_tok.cnt  = '0;
    end else begin
      head_tok = last_tok;
      // drop a finished pixel from the ring once the output register takes it
      if (exit_ok) begin
        head_tok.vld = 1'b0;
      end
    end
  end

  assign cell_in[0] = head_tok;

  for (genvar gi = 1; gi < NUM_CELLS; gi++) begin : g_link
    assign cell_in[gi] = cell_out[gi-1];
  end

  for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    mandel_cell #(.MAX_ITER(MAX_ITER)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (cell_in[gi]),
      .tok_out (cell_out[gi])
    );
  end

  // Colour stage
  always_comb begin
    cnt_wide          = COLOR_W'(last_tok.cnt);
    result.inside_set = (last_tok.cnt == MAX_CNT);
    result.iter_count = last_tok.cnt[ITER_W-1:0];
    if (result.inside_set) begin
      result.pixel_color = INSIDE_COLOR;
    end else begin
      result.pixel_color = cnt_wide * COLOR_W'(COLOR_STEP) + COLOR_W'(color_ofs_r);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_PROD;
      S_PROD:  state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_re_done) state_nxt = S_MAP;
      S_MAP:   state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_RUN;
      S_RUN:   if (exit_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exit_ok) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !last_tok.vld)
    else $error("ring holds a pixel while the block is idle");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_re_done == div_im_done)
    else $error("column and row dividers out of step");

  a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    exit_ok |-> (state_r == S_RUN))
    else $error("pixel left the ring outside the run state");

  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.inside_set) |-> (out_data.iter_count == ITER_W'(MAX_ITER)))
    else $error("inside flag without full iteration count");

endmodule

>>> hw/rtl/mandel_div.sv
// Division of an unsigned magnitude by a fixed divisor via reciprocal multiplication.
module mandel_div import mandel_pkg::*; #(
  parameter int DIVISOR = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  // floor(n / D) equals floor(n * M / 2^K) for every n below 2^DIV_W when
  // K = DIV_W + ceil(log2 D) and M = ceil(2^K / D); M fits in DIV_W + 1 bits
  localparam int SH_W   = $clog2(DIVISOR);
  localparam int K_SH   = DIV_W + SH_W;
  localparam int M_W    = DIV_W + 1;
  localparam int HALF_W = M_W / 2;
  localparam int PP_W   = 2 * HALF_W;
  localparam int SUM_W  = K_SH + DIV_W;
  localparam longint unsigned RECIP =
    ((64'd1 << K_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [M_W-1:0]    RECIP_M  = M_W'(RECIP);
  localparam logic [HALF_W-1:0] RECIP_HI = RECIP_M[M_W-1:HALF_W];
  localparam logic [HALF_W-1:0] RECIP_LO = RECIP_M[HALF_W-1:0];

  logic [M_W-1:0]    num;
  logic [HALF_W-1:0] num_hi, num_lo;
  logic              v1_r;
  logic              done_r;
  logic [PP_W-1:0]   pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [SUM_W-1:0]  sum;
  logic [DIV_W-1:0]  quo_r;

  assign num    = {1'b0, dividend};
  assign num_hi = num[M_W-1:HALF_W];
  assign num_lo = num[HALF_W-1:0];

  // Align the partial products; the quotient sits above the K fraction bits
  always_comb begin
    sum = SUM_W'(pp_ll_r)
        + (SUM_W'(pp_lh_r) << HALF_W)
        + (SUM_W'(pp_hl_r) << HALF_W)
        + (SUM_W'(pp_hh_r) << PP_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pp_ll_r <= num_lo * RECIP_LO;
      pp_lh_r <= num_lo * RECIP_HI;
      pp_hl_r <= num_hi * RECIP_LO;
      pp_hh_r <= num_hi * RECIP_HI;
    end
    if (v1_r) begin
      quo_r <= sum[SUM_W-1:K_SH];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/mandel_cell.sv
// One iteration cell: square stage, then update, escape test and saturation.
module mandel_cell import mandel_pkg::*; #(
  parameter int MAX_ITER = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mandel_tok_t tok_in,
  output mandel_tok_t tok_out
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITER);

  typedef struct packed {
    logic                    vld;
    logic                    done;
    logic signed [2*Q_W-1:0] rr;
    logic signed [2*Q_W-1:0] ii;
    logic signed [2*Q_W-1:0] ri;
    logic signed [Q_W-1:0]   cr;
    logic signed [Q_W-1:0]   ci;
    logic        [CNT_W-1:0] cnt;
  } sq_t;

  sq_t         sq_r, sq_nxt;
  mandel_tok_t up_r, up_nxt;

  logic [2*Q_W-1:0]        mag2;
  logic signed [2*Q_W-1:0] re_diff;
  logic signed [WIDE_W-1:0] nr_wide;
  logic signed [WIDE_W-1:0] ni_wide;
  logic                    esc;
  logic                    stop;

  always_comb begin
    sq_nxt.vld  = tok_in.vld;
    sq_nxt.done = tok_in.done;
    sq_nxt.rr   = tok_in.zr * tok_in.zr;
    sq_nxt.ii   = tok_in.zi * tok_in.zi;
    sq_nxt.ri   = tok_in.zr * tok_in.zi;
    sq_nxt.cr   = tok_in.cr;
    sq_nxt.ci   = tok_in.ci;
    sq_nxt.cnt  = tok_in.cnt;
  end

  always_comb begin
    mag2    = $unsigned(sq_r.rr) + $unsigned(sq_r.ii);
    esc     = (mag2 > ESC_LIMIT);
    stop    = sq_r.done || (sq_r.cnt == MAX_CNT) || esc;
    re_diff = sq_r.rr - sq_r.ii;
    // floor shifts: the arithmetic slices drop fraction bits toward minus infinity
    nr_wide = WIDE_W'($signed(re_diff[2*Q_W-1:FRAC_W])) + WIDE_W'(sq_r.cr);
    ni_wide = WIDE_W'($signed(sq_r.ri[2*Q_W-1:FRAC_W-1])) + WIDE_W'(sq_r.ci);

    up_nxt.vld  = sq_r.vld;
    up_nxt.done = stop;
    up_nxt.cr   = sq_r.cr;
    up_nxt.ci   = sq_r.ci;
    if (stop) begin
      // hold the count; z no longer matters once the pixel is finished
      up_nxt.zr  = '0;
      up_nxt.zi  = '0;
      up_nxt.cnt = sq_r.cnt;
    end else begin
      up_nxt.zr  = sat_q(nr_wide);
      up_nxt.zi  = sat_q(ni_wide);
      up_nxt.cnt = sq_r.cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.vld <= 1'b0;
      up_r.vld <= 1'b0;
    end else begin
      sq_r <= sq_nxt;
      up_r <= up_nxt;
    end
  end

  assign tok_out = up_r;

endmodule
